/* rtl/bmp_pkg.sv */
// package for the binomial mod prime core: types and constants
package bmp_pkg;

    localparam int MAX_N    = 4095;
    localparam int IDX_W    = 12;
    localparam int VAL_W    = 30;
    localparam logic [29:0] PRIME = 30'd1000000007;
    localparam logic [29:0] EXP_TOP = 30'd1000000005;
    localparam int EXP_W    = 30;

    // barrett constant floor(2^60 / p)
    localparam logic [30:0] BARRETT_MU = 31'(64'h1000_0000_0000_0000 / 64'(PRIME));

    typedef struct packed {
        logic [IDX_W-1:0] n_value;
        logic [IDX_W-1:0] k_value;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] binom_value;
        logic             range_error;
    } t_out;

endpackage

/* rtl/bmp_mulmod.sv */
// pipelined modular multiplier with barrett reduction, five register stages
module bmp_mulmod (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [29:0] i_a,
    input  logic [29:0] i_b,
    output logic [29:0] o_p
);
    import bmp_pkg::*;

    localparam logic [31:0] P_X1 = {2'b00, PRIME};
    localparam logic [31:0] P_X2 = {1'b0, PRIME, 1'b0};

    logic [59:0] r_prod;
    logic [61:0] r_qm;
    logic [31:0] r_x2;
    logic [31:0] r_qp;
    logic [31:0] r_x3;
    logic [31:0] r_rem;
    logic [29:0] w_red;

    // remainder is below 3p, trim with two parallel compares
    always_comb begin
        if (r_rem >= P_X2) begin
            w_red = 30'(r_rem - P_X2);
        end else if (r_rem >= P_X1) begin
            w_red = 30'(r_rem - P_X1);
        end else begin
            w_red = r_rem[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 60'(i_a) * 60'(i_b);
            r_qm   <= 62'(r_prod[59:29]) * 62'(BARRETT_MU);
            r_x2   <= r_prod[31:0];
            // only the low 32 bits of q*p are needed
            r_qp   <= 32'(r_qm[61:31]) * 32'(PRIME);
            r_x3   <= r_x2;
            r_rem  <= r_x3 - r_qp;
            o_p    <= w_red;
        end
    end

endmodule

/* rtl/binomial_mod_prime_core.sv */
// binomial coefficient mod 1000000007 core with factorial and inverse tables
// throughput: one request per cycle once tables are built; a held result stalls the pipe
// after reset a build sequence fills fact[] (4095 steps), runs 30-bit fermat
// exponentiation (59 multiplies) and fills inv[] downward (4095 steps); ready
// stays low while this runs
module binomial_mod_prime_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bmp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bmp_pkg::t_out o_data
);
    import bmp_pkg::*;

    localparam logic [2:0] S_FACT = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_INV  = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;
    localparam int MUL_STG = 5;
    localparam int MUL_LAT = 6;
    localparam int LAT = 13;
    localparam int ERR_LEN = 11;

    logic [29:0] r_fact [0:MAX_N];
    logic [29:0] r_inv  [0:MAX_N];

    logic [2:0]  r_state;
    logic [12:0] r_idx;
    logic [2:0]  r_wait;
    logic [29:0] r_acc;
    logic [29:0] r_base;
    logic [EXP_W-1:0] r_exp;

    // shared multiplier, time-multiplexed between build and query stage two
    logic        w_en;
    logic [29:0] w_ma, w_mb, w_mp;
    logic [29:0] w_qa, w_qb, w_qp;

    // table write ports
    logic        w_fact_we;
    logic [11:0] w_fact_addr;
    logic [29:0] w_fact_data;
    logic        w_inv_we;
    logic [11:0] w_inv_addr;
    logic [29:0] w_inv_data;

    // query pipeline occupancy and stall
    logic [LAT-1:0] r_v;
    logic           w_adv;

    // stage 0: registered request
    logic [11:0] r_q0_n, r_q0_k, r_q0_d;
    logic        r_q0_err;
    // stage 1: registered table reads
    logic [29:0] r_q1_fact, r_q1_ik, r_q1_id;
    logic [29:0] r_d1 [0:MUL_STG-1];
    logic        r_e  [0:ERR_LEN-1];
    logic [29:0] r_res;
    logic        r_err;

    assign w_adv = !o_valid || i_ready;
    assign w_en  = (r_state != S_RUN) || w_adv;

    bmp_mulmod u_mul_a (.i_clk(i_clk), .i_en(w_en), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));
    bmp_mulmod u_mul_b (.i_clk(i_clk), .i_en(w_en), .i_a(w_qa), .i_b(w_qb), .o_p(w_qp));

    // ---------------- build sequencer ----------------
    logic w_step;
    assign w_step = (r_wait == 3'(MUL_LAT - 1));

    always_comb begin
        w_ma = r_acc;
        w_mb = r_base;
        case (r_state)
            S_FACT:  begin w_ma = r_acc; w_mb = 30'(r_idx); end
            S_SQ:    begin w_ma = r_base; w_mb = r_base; end
            S_MUL:   begin w_ma = r_acc; w_mb = r_base; end
            S_INV:   begin w_ma = r_acc; w_mb = 30'(r_idx); end
            default: begin w_ma = r_q1_fact; w_mb = r_q1_ik; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FACT;
            r_idx   <= 13'd1;
            r_wait  <= '0;
            r_acc   <= 30'd1;
            r_exp   <= EXP_TOP;
        end else if (r_state != S_RUN) begin
            r_wait <= w_step ? '0 : r_wait + 3'd1;
            if (w_step) begin
                case (r_state)
                    S_FACT: begin
                        r_acc <= w_mp;
                        if (r_idx == 13'(MAX_N)) begin
                            r_base  <= w_mp;
                            r_acc   <= 30'd1;
                            r_state <= S_MUL;
                        end else begin
                            r_idx <= r_idx + 13'd1;
                        end
                    end
                    S_MUL: begin
                        if (r_exp[0]) r_acc <= w_mp;
                        r_exp   <= r_exp >> 1;
                        r_state <= (r_exp == 30'd1) ? S_INV : S_SQ;
                    end
                    S_SQ: begin
                        r_base  <= w_mp;
                        r_state <= S_MUL;
                    end
                    S_INV: begin
                        r_acc <= w_mp;
                        if (r_idx == 13'd1) r_state <= S_RUN;
                        else r_idx <= r_idx - 13'd1;
                    end
                    default: r_state <= S_RUN;
                endcase
            end
        end
    end

    // table writes: fact entry below the index and inv entry at the index at step start, top or bottom entry at the end
    assign w_fact_we   = (r_state == S_FACT) &&
                         ((r_wait == '0) || (w_step && r_idx == 13'(MAX_N)));
    assign w_fact_addr = (r_wait == '0) ? r_idx[11:0] - 12'd1 : 12'(MAX_N);
    assign w_fact_data = (r_wait == '0) ? r_acc : w_mp;
    assign w_inv_we    = (r_state == S_INV) &&
                         ((r_wait == '0) || (w_step && r_idx == 13'd1));
    assign w_inv_addr  = (r_wait == '0) ? r_idx[11:0] : 12'd0;
    assign w_inv_data  = (r_wait == '0) ? r_acc : w_mp;

    always_ff @(posedge i_clk) begin
        if (w_fact_we) r_fact[w_fact_addr] <= w_fact_data;
        if (w_inv_we) r_inv[w_inv_addr] <= w_inv_data;
    end

    // ---------------- query pipeline ----------------
    assign o_ready = (r_state == S_RUN) && w_adv;

    assign w_qa = w_mp;
    assign w_qb = r_d1[MUL_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[LAT-2:0], i_valid && o_ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_state == S_RUN) begin
            r_q0_n   <= i_data.n_value;
            r_q0_k   <= i_data.k_value;
            r_q0_d   <= i_data.n_value - i_data.k_value;
            r_q0_err <= i_data.k_value > i_data.n_value;
            r_q1_fact <= r_fact[r_q0_n];
            r_q1_ik   <= r_inv[r_q0_k];
            r_q1_id   <= r_inv[r_q0_d];
            r_e[0] <= r_q0_err;
            for (int j = 1; j < ERR_LEN; j++) r_e[j] <= r_e[j-1];
            r_d1[0] <= r_q1_id;
            for (int j = 1; j < MUL_STG; j++) r_d1[j] <= r_d1[j-1];
            r_res <= r_e[ERR_LEN-1] ? 30'd0 : w_qp;
            r_err <= r_e[ERR_LEN-1];
        end
    end

    // stage timing: req(0) read(1) mul a(2..6) mul b(7..11) result register(12)
    assign o_valid            = r_v[LAT-1];
    assign o_data.binom_value = r_res;
    assign o_data.range_error = r_err;

    a_ready_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_RUN) else $error("ready during build");
    a_no_out_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_RUN |-> !o_valid) else $error("result during build");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.range_error |-> o_data.binom_value == 30'd0)
        else $error("error result not zero");

endmodule
